// ===== hdl/pll_pkg.sv =====
// Package with the word types, action and status codes and the engine states.
package pll_pkg;

  // Action codes of an input word.
  localparam logic [1:0] ACT_APPEND     = 2'd0;
  localparam logic [1:0] ACT_REMOVE_VAL = 2'd1;
  localparam logic [1:0] ACT_REMOVE_ALL = 2'd2;
  localparam logic [1:0] ACT_GET        = 2'd3;

  // Status codes of a result word.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NO_ROOM   = 2'd1;
  localparam logic [1:0] ST_OUT_RANGE = 2'd2;

  // Input word.
  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] value;
    logic [7:0]  position;
  } in_word_t;

  // Result word.
  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] read_value;
    logic [8:0]  entry_count;
  } out_word_t;

  // Back-end sequencer states.
  typedef enum logic [2:0] {
    ENG_IDLE,
    ENG_FIND,
    ENG_WALK,
    ENG_READ,
    ENG_DONE
  } eng_state_t;

endpackage

// ===== hdl/pool_linked_list_engine_top.sv =====
// Top level of the linked-list engine over a fixed slot pool.
//
//   channel | direction | payload             | handshake
//   in_     | input     | pll_pkg::in_word_t  | in_valid / in_stall
//   out_    | output    | pll_pkg::out_word_t | out_valid / out_stall
//
// An append runs the one-slot-per-cycle free search, then links the found slot at the tail.
// Remove by value and get walk the list from the head, one link per cycle.
// Remove all and an out-of-range get skip the walk and go straight to the result.
// Reset empties the list; slot contents stay undefined until appended.
// A two-word input queue takes words while the engine works or its result waits.
module pool_linked_list_engine_top #(
  parameter int LIST_DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  pll_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output pll_pkg::out_word_t out_data
);

  logic              q_valid, q_take;
  pll_pkg::in_word_t q_data;

  pll_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_data,
    .q_valid, .q_take, .q_data
  );

  pll_engine #(.LIST_DEPTH(LIST_DEPTH)) u_engine (
    .clk, .rst_n, .q_valid, .q_take, .q_data,
    .out_valid, .out_stall, .out_data
  );

endmodule

// ===== hdl/pll_front.sv =====
// Front end: accepts input words into a two-entry queue toward the engine.
module pll_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  pll_pkg::in_word_t in_data,
  output logic              q_valid,
  input  logic              q_take,
  output pll_pkg::in_word_t q_data
);

  pll_pkg::in_word_t mem_r [2];
  logic              wr_ptr_r, rd_ptr_r;
  logic [1:0]        cnt_r;
  logic              push, pop;

  assign in_stall = (cnt_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign pop      = q_take && q_valid;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_data   = mem_r[rd_ptr_r];

  // Queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= in_data;
  end

endmodule

// ===== hdl/pll_engine.sv =====
// Back end: sequencer that carries out list actions over the slot pool.
module pll_engine #(
  parameter int LIST_DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  output logic               q_take,
  input  pll_pkg::in_word_t  q_data,
  output logic               out_valid,
  input  logic               out_stall,
  output pll_pkg::out_word_t out_data
);

  localparam int PW = $clog2(LIST_DEPTH + 1);
  localparam int IW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam logic [PW-1:0] NULL_P = PW'(LIST_DEPTH);

  // Slot storage; used flags live in flip-flops.
  logic [31:0]     val_mem [LIST_DEPTH];
  logic [PW-1:0]   nxt_mem [LIST_DEPTH];
  logic [LIST_DEPTH-1:0] used_r, used_nxt;

  pll_pkg::eng_state_t state_r, state_nxt;
  pll_pkg::in_word_t   cmd_r, cmd_nxt;
  logic [PW-1:0] head_r, head_nxt, tail_r, tail_nxt;
  logic [PW-1:0] cnt_r, cnt_nxt;
  logic [PW-1:0] cur_r, cur_nxt, prev_r, prev_nxt;
  logic [8:0]    step_r, step_nxt;
  logic [1:0]    st_r, st_nxt;
  logic [31:0]   rv_r, rv_nxt;
  logic          ov_r, ov_nxt;
  pll_pkg::out_word_t od_r, od_nxt;

  logic          wv_en, wn_en;
  logic [IW-1:0] wv_a, wn_a;
  logic [31:0]   wv_d;
  logic [PW-1:0] wn_d;
  logic [IW-1:0] cur_i;
  logic [IW-1:0] rd_a;
  logic [31:0]   cur_val_r;
  logic [PW-1:0] cur_nx_r;

  assign out_valid = ov_r;
  assign out_data  = od_r;
  assign cur_i     = cur_r[IW-1:0];
  // The slot read is issued with the next slot pointer, so its data lines up with cur_r.
  assign rd_a      = cur_nxt[IW-1:0];

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pll_pkg::ENG_IDLE;
      used_r  <= '0;
      head_r  <= NULL_P;
      tail_r  <= NULL_P;
      cnt_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      used_r  <= used_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      cnt_r   <= cnt_nxt;
      ov_r    <= ov_nxt;
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    cmd_r  <= cmd_nxt;
    cur_r  <= cur_nxt;
    prev_r <= prev_nxt;
    step_r <= step_nxt;
    st_r   <= st_nxt;
    rv_r   <= rv_nxt;
    od_r   <= od_nxt;
  end

  // Slot memories with registered reads.
  always_ff @(posedge clk) begin
    if (wv_en) val_mem[wv_a] <= wv_d;
    if (wn_en) nxt_mem[wn_a] <= wn_d;
    cur_val_r <= val_mem[rd_a];
    cur_nx_r  <= nxt_mem[rd_a];
  end

  // Sequencer: while searching or walking, one slot is visited per cycle.
  always_comb begin
    state_nxt = state_r;
    cmd_nxt   = cmd_r;
    used_nxt  = used_r;
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    cnt_nxt   = cnt_r;
    cur_nxt   = cur_r;
    prev_nxt  = prev_r;
    step_nxt  = step_r;
    st_nxt    = st_r;
    rv_nxt    = rv_r;
    ov_nxt    = ov_r && out_stall;
    od_nxt    = od_r;
    q_take    = 1'b0;
    wv_en = 1'b0; wv_a = '0; wv_d = '0;
    wn_en = 1'b0; wn_a = '0; wn_d = '0;
    case (state_r)
      pll_pkg::ENG_IDLE: begin
        if (q_valid) begin
          q_take    = 1'b1;
          cmd_nxt   = q_data;
          cur_nxt   = (q_data.action == pll_pkg::ACT_APPEND) ? '0 : head_r;
          prev_nxt  = NULL_P;
          step_nxt  = '0;
          st_nxt    = pll_pkg::ST_OK;
          rv_nxt    = '0;
          state_nxt = (q_data.action == pll_pkg::ACT_APPEND) ? pll_pkg::ENG_FIND
                                                             : pll_pkg::ENG_WALK;
          if (q_data.action == pll_pkg::ACT_REMOVE_ALL) begin
            used_nxt  = '0;
            head_nxt  = NULL_P;
            tail_nxt  = NULL_P;
            cnt_nxt   = '0;
            state_nxt = pll_pkg::ENG_DONE;
          end else if (q_data.action == pll_pkg::ACT_GET &&
                       9'(q_data.position) >= 9'(cnt_r)) begin
            st_nxt    = pll_pkg::ST_OUT_RANGE;
            state_nxt = pll_pkg::ENG_DONE;
          end
        end
      end
      // Lowest free slot search, then link at the tail.
      pll_pkg::ENG_FIND: begin
        if (cur_r == NULL_P) begin
          st_nxt    = pll_pkg::ST_NO_ROOM;
          state_nxt = pll_pkg::ENG_DONE;
        end else if (!used_r[cur_i]) begin
          used_nxt[cur_i] = 1'b1;
          wv_en = 1'b1; wv_a = cur_i; wv_d = cmd_r.value;
          if (head_r == NULL_P || tail_r == NULL_P) begin
            head_nxt = cur_r;
            cnt_nxt  = PW'(1);
          end else begin
            wn_en   = 1'b1; wn_a = tail_r[IW-1:0]; wn_d = cur_r;
            cnt_nxt = cnt_r + PW'(1);
          end
          tail_nxt  = cur_r;
          prev_nxt  = cur_r;
          state_nxt = pll_pkg::ENG_READ;
        end else begin
          cur_nxt = cur_r + PW'(1);
        end
      end
      // Terminate the new slot's link.
      pll_pkg::ENG_READ: begin
        wn_en = 1'b1; wn_a = prev_r[IW-1:0]; wn_d = NULL_P;
        state_nxt = pll_pkg::ENG_DONE;
      end
      // Walk from the head for removal or get.
      pll_pkg::ENG_WALK: begin
        if (cur_r == NULL_P || step_r >= 9'(LIST_DEPTH)) begin
          state_nxt = pll_pkg::ENG_DONE;
        end else if (cmd_r.action == pll_pkg::ACT_GET) begin
          if (step_r == 9'(cmd_r.position)) begin
            rv_nxt    = cur_val_r;
            state_nxt = pll_pkg::ENG_DONE;
          end else begin
            cur_nxt  = cur_nx_r;
            step_nxt = step_r + 9'd1;
          end
        end else begin
          if (cur_val_r == cmd_r.value) begin
            if (cur_r == head_r) head_nxt = cur_nx_r;
            if (cur_r == tail_r) tail_nxt = prev_r;
            if (prev_r != NULL_P) begin
              wn_en = 1'b1; wn_a = prev_r[IW-1:0]; wn_d = cur_nx_r;
            end
            used_nxt[cur_i] = 1'b0;
            if (cnt_r != '0) cnt_nxt = cnt_r - PW'(1);
          end else begin
            prev_nxt = cur_r;
          end
          cur_nxt  = cur_nx_r;
          step_nxt = step_r + 9'd1;
        end
      end
      // Hand the result to the output register.
      pll_pkg::ENG_DONE: begin
        if (!ov_r || !out_stall) begin
          ov_nxt = 1'b1;
          od_nxt.status      = st_r;
          od_nxt.read_value  = rv_r;
          od_nxt.entry_count = 9'(cnt_r);
          state_nxt = pll_pkg::ENG_IDLE;
        end
      end
      default: state_nxt = pll_pkg::ENG_IDLE;
    endcase
  end

endmodule
